// ===== hdl/trrs_pkg.sv =====
// Package for the time-of-flight range result block.
// Holds status codes, raw device status values, register indexes and fixed widths.
// No dependencies.
package trrs_pkg;

   localparam int unsigned GAIN_W   = 12;
   localparam int unsigned RATE_W   = 16;
   localparam int unsigned STAT_W   = 4;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned CSR_W    = 16;

   // Cycles from the accepting edge to the edge that takes the result.
   localparam int unsigned LATENCY  = 50;

   localparam logic [GAIN_W-1:0] GAIN_RESET   = 12'd2011;
   localparam logic [RATE_W-1:0] TARGET_RESET = 16'h0A00;
   localparam logic [RATE_W-1:0] SPAD_MID     = 16'h8000;
   localparam logic [RATE_W-1:0] CLIP16       = 16'hFFFF;
   localparam logic [28:0]       ROUND_HALF   = 29'h0400;

   typedef enum logic {
      CSR_RANGE_GAIN  = 1'b0,
      CSR_DSS_TARGET  = 1'b1
   } csr_index_type;

   typedef enum logic [STAT_W-1:0] {
      ST_VALID   = 4'd0,
      ST_SIGMA   = 4'd1,
      ST_SIGNAL  = 4'd2,
      ST_MINCLIP = 4'd3,
      ST_BOUNDS  = 4'd4,
      ST_HW      = 4'd5,
      ST_NOWRAP  = 4'd6,
      ST_WRAP    = 4'd7,
      ST_XTALK   = 4'd8,
      ST_SYNC    = 4'd9,
      ST_ROI     = 4'd10,
      ST_NONE    = 4'd11
   } status_type;

   localparam logic [BYTE_W-1:0] DEV_HW_A    = 8'd1;
   localparam logic [BYTE_W-1:0] DEV_HW_B    = 8'd2;
   localparam logic [BYTE_W-1:0] DEV_HW_C    = 8'd3;
   localparam logic [BYTE_W-1:0] DEV_SIGNAL  = 8'd4;
   localparam logic [BYTE_W-1:0] DEV_BOUNDS  = 8'd5;
   localparam logic [BYTE_W-1:0] DEV_SIGMA   = 8'd6;
   localparam logic [BYTE_W-1:0] DEV_WRAP    = 8'd7;
   localparam logic [BYTE_W-1:0] DEV_MINCLIP = 8'd8;
   localparam logic [BYTE_W-1:0] DEV_RANGE   = 8'd9;
   localparam logic [BYTE_W-1:0] DEV_XTALK   = 8'd12;
   localparam logic [BYTE_W-1:0] DEV_ROI     = 8'd13;
   localparam logic [BYTE_W-1:0] DEV_HW_D    = 8'd17;
   localparam logic [BYTE_W-1:0] DEV_SYNC    = 8'd18;

endpackage

// ===== hdl/trrs_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Carries a valid bit and a sideband word alongside. No package needed.
module trrs_div #(
   parameter int unsigned DEN_W  = 16,
   parameter int unsigned Q_W    = 32,
   parameter int unsigned SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [DEN_W-1:0]  in_rem,
   input  logic [Q_W-1:0]    in_bits,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [Q_W-1:0]    out_quo,
   output logic [SIDE_W-1:0] out_side
);

   logic              vld_ff  [Q_W];
   logic [DEN_W-1:0]  rem_ff  [Q_W];
   logic [Q_W-1:0]    bits_ff [Q_W];
   logic [DEN_W-1:0]  den_ff  [Q_W];
   logic [SIDE_W-1:0] side_ff [Q_W];

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      logic              p_vld;
      logic [DEN_W-1:0]  p_rem;
      logic [Q_W-1:0]    p_bits;
      logic [DEN_W-1:0]  p_den;
      logic [SIDE_W-1:0] p_side;
      logic [DEN_W:0]    trial;
      logic [DEN_W:0]    diff;
      logic              ge;
      logic [DEN_W-1:0]  rem_in;
      logic [Q_W-1:0]    bits_in;

      if (k == 0) begin : g_first
         assign p_vld  = in_valid;
         assign p_rem  = in_rem;
         assign p_bits = in_bits;
         assign p_den  = in_den;
         assign p_side = in_side;
      end else begin : g_next
         assign p_vld  = vld_ff[k-1];
         assign p_rem  = rem_ff[k-1];
         assign p_bits = bits_ff[k-1];
         assign p_den  = den_ff[k-1];
         assign p_side = side_ff[k-1];
      end

      // Shift the next dividend bit into the partial remainder, keep the difference if it fits.
      always_comb begin
         trial   = {p_rem, p_bits[Q_W-1]};
         diff    = trial - {1'b0, p_den};
         ge      = (trial >= {1'b0, p_den});
         rem_in  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         bits_in = {p_bits[Q_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= p_vld;
         end
         rem_ff[k]  <= rem_in;
         bits_ff[k] <= bits_in;
         den_ff[k]  <= p_den;
         side_ff[k] <= p_side;
      end
   end

   assign out_valid = vld_ff[Q_W-1];
   assign out_quo   = bits_ff[Q_W-1];
   assign out_side  = side_ff[Q_W-1];

endmodule

// ===== hdl/tof_result_range_status_dss.sv =====
// Time-of-flight range result conversion: gain-scaled range, dense status code
// and a new requested effective SPAD count. Uses trrs_pkg and trrs_div.
//
// Usage:
//   Input: drive the req_ fields and raise start; the item is taken at an edge
//   where start is high and busy is low. busy is low except during reset, so a
//   new item can enter every cycle.
//   Output: rsp_valid strobes for one cycle with rsp_dist_mm, rsp_stat_code
//   and rsp_requested_spads. The receiver cannot stall; results arrive in order.
//   Throughput: one item per cycle. The pipeline is two bit-per-stage
//   dividers: 32 stages for the per-SPAD rate and 16 for the SPAD request, plus
//   one input stage (multiply, status map, rate sum) and one output register.
//   Configuration: csr_we writes csr_wdata into register csr_index
//   (0 range_gain, 1 dss_target_rate); write only while no item is in flight.
//   Reset: synchronous; clears all valid bits, loads range_gain 2011 and
//   dss_target_rate 0x0A00. Items in flight are dropped.
module tof_result_range_status_dss (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [trrs_pkg::BYTE_W-1:0]   req_device_status,
   input  logic [trrs_pkg::BYTE_W-1:0]   req_stream_count,
   input  logic [trrs_pkg::RATE_W-1:0]   req_effective_spads,
   input  logic [trrs_pkg::RATE_W-1:0]   req_ambient_rate,
   input  logic [trrs_pkg::RATE_W-1:0]   req_raw_range,
   input  logic [trrs_pkg::RATE_W-1:0]   req_peak_signal_rate,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [trrs_pkg::CSR_W-1:0]    csr_wdata,
   output logic                          rsp_valid,
   output logic [trrs_pkg::RATE_W-1:0]   rsp_dist_mm,
   output logic [trrs_pkg::STAT_W-1:0]   rsp_stat_code,
   output logic [trrs_pkg::RATE_W-1:0]   rsp_requested_spads
);
   import trrs_pkg::*;

   localparam int unsigned SIDE1_W = RATE_W + STAT_W + 1;
   localparam int unsigned SIDE2_W = RATE_W + STAT_W + 2;

   logic [GAIN_W-1:0] gain_ff;
   logic [RATE_W-1:0] target_ff;

   logic              s1_vld_ff;
   logic [27:0]       s1_prod_ff;
   logic [STAT_W-1:0] s1_stat_ff;
   logic [RATE_W-1:0] s1_sum_ff;
   logic [RATE_W-1:0] s1_spads_ff;
   logic              s1_zero_ff;

   logic [STAT_W-1:0] stat_in;
   logic [RATE_W:0]   sum_wide;
   logic [RATE_W-1:0] sum_in;

   logic [28:0]       rounded;
   logic [RATE_W-1:0] range_sat;

   logic               d1_vld;
   logic [31:0]        d1_quo;
   logic [SIDE1_W-1:0] d1_side;
   logic               clip;

   logic               d2_vld;
   logic [RATE_W-1:0]  d2_quo;
   logic [SIDE2_W-1:0] d2_side;

   logic              rsp_valid_ff;
   logic [RATE_W-1:0] rsp_range_ff;
   logic [STAT_W-1:0] rsp_stat_ff;
   logic [RATE_W-1:0] rsp_spads_ff;
   logic [RATE_W-1:0] spads_in;

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= GAIN_RESET;
         target_ff <= TARGET_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_RANGE_GAIN: gain_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_DSS_TARGET: target_ff <= csr_wdata[RATE_W-1:0];
            default:        gain_ff   <= gain_ff;
         endcase
      end
   end

   always_comb begin
      case (req_device_status) inside
         DEV_HW_A, DEV_HW_B, DEV_HW_C, DEV_HW_D: stat_in = ST_HW;
         DEV_ROI:     stat_in = ST_ROI;
         DEV_SYNC:    stat_in = ST_SYNC;
         DEV_BOUNDS:  stat_in = ST_BOUNDS;
         DEV_SIGNAL:  stat_in = ST_SIGNAL;
         DEV_SIGMA:   stat_in = ST_SIGMA;
         DEV_WRAP:    stat_in = ST_WRAP;
         DEV_XTALK:   stat_in = ST_XTALK;
         DEV_MINCLIP: stat_in = ST_MINCLIP;
         DEV_RANGE:   stat_in = (req_stream_count == '0) ? ST_NOWRAP : ST_VALID;
         default:     stat_in = ST_NONE;
      endcase
      sum_wide = {1'b0, req_peak_signal_rate} + {1'b0, req_ambient_rate};
      sum_in   = sum_wide[RATE_W] ? CLIP16 : sum_wide[RATE_W-1:0];
   end

   // Input stage: multiply, map status, clip the rate sum.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= start && !busy;
      end
      s1_prod_ff  <= req_raw_range * gain_ff;
      s1_stat_ff  <= stat_in;
      s1_sum_ff   <= sum_in;
      s1_spads_ff <= req_effective_spads;
      // zero SPAD count, or zero rate sum (the only case of zero per-SPAD rate)
      s1_zero_ff  <= (req_effective_spads == '0) || (sum_in == '0);
   end

   always_comb begin
      rounded   = {1'b0, s1_prod_ff} + ROUND_HALF;
      range_sat = (rounded[28:27] != 2'b00) ? CLIP16 : rounded[26:11];
   end

   trrs_div #(.DEN_W(RATE_W), .Q_W(32), .SIDE_W(SIDE1_W)) u_div_rate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_vld_ff),
      .in_rem    ('0),
      .in_bits   ({s1_sum_ff, 16'h0000}),
      .in_den    (s1_spads_ff),
      .in_side   ({range_sat, s1_stat_ff, s1_zero_ff}),
      .out_valid (d1_vld),
      .out_quo   (d1_quo),
      .out_side  (d1_side)
   );

   // Quotient overflows 16 bits exactly when per-SPAD rate is at most the target.
   assign clip = (d1_quo <= {16'h0000, target_ff});

   trrs_div #(.DEN_W(32), .Q_W(RATE_W), .SIDE_W(SIDE2_W)) u_div_req (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d1_vld),
      .in_rem    ({16'h0000, target_ff}),
      .in_bits   ('0),
      .in_den    (d1_quo),
      .in_side   ({d1_side, clip}),
      .out_valid (d2_vld),
      .out_quo   (d2_quo),
      .out_side  (d2_side)
   );

   always_comb begin
      if (d2_side[1]) begin
         spads_in = SPAD_MID;
      end else if (d2_side[0]) begin
         spads_in = CLIP16;
      end else begin
         spads_in = d2_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= d2_vld;
      end
      rsp_range_ff <= d2_side[SIDE2_W-1 -: RATE_W];
      rsp_stat_ff  <= d2_side[STAT_W+1:2];
      rsp_spads_ff <= spads_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_dist_mm         = rsp_range_ff;
   assign rsp_stat_code       = rsp_stat_ff;
   assign rsp_requested_spads = rsp_spads_ff;

endmodule

// ===== hdl/trrs_chk.sv =====
// Port-level checker for the range result block, bound to the top level.
// Uses trrs_pkg for latency and status codes.
module trrs_chk (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [trrs_pkg::BYTE_W-1:0]   req_device_status,
   input logic [trrs_pkg::BYTE_W-1:0]   req_stream_count,
   input logic [trrs_pkg::RATE_W-1:0]   req_effective_spads,
   input logic                          rsp_valid,
   input logic [trrs_pkg::STAT_W-1:0]   rsp_stat_code,
   input logic [trrs_pkg::RATE_W-1:0]   rsp_requested_spads
);
   import trrs_pkg::*;

   a_no_result_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");

   a_result_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without an item accepted at the pipeline latency");

   a_zero_spads: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(start && !busy && req_effective_spads == '0, LATENCY)
      |-> rsp_requested_spads == SPAD_MID)
      else $error("zero SPAD count did not give the midpoint request");

   a_valid_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(start && !busy && req_device_status == DEV_RANGE
                         && req_stream_count != '0, LATENCY)
      |-> rsp_stat_code == ST_VALID)
      else $error("valid range status lost through the pipeline");

endmodule

bind tof_result_range_status_dss trrs_chk u_trrs_chk (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .req_device_status   (req_device_status),
   .req_stream_count    (req_stream_count),
   .req_effective_spads (req_effective_spads),
   .rsp_valid           (rsp_valid),
   .rsp_stat_code       (rsp_stat_code),
   .rsp_requested_spads (rsp_requested_spads)
);

// ===== verif/tb.sv =====
// Testbench for tof_result_range_status_dss: random and directed readouts, with
// a built-in predictor of range scaling, status mapping and SPAD request.
// Depends on trrs_pkg and the block's RTL.
module tb;
   import trrs_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] dev;
      logic [BYTE_W-1:0] stream;
      logic [RATE_W-1:0] spads;
      logic [RATE_W-1:0] ambient;
      logic [RATE_W-1:0] raw;
      logic [RATE_W-1:0] peak;
   } readout_type;

   typedef struct packed {
      logic [RATE_W-1:0] dist_mm;
      status_type        status;
      logic [RATE_W-1:0] spads_req;
   } conversion_type;

   localparam int unsigned WATCHDOG_LIMIT = 4000;

   logic clock, reset, start, busy, csr_we, csr_index, rsp_valid;
   logic [BYTE_W-1:0] req_device_status, req_stream_count;
   logic [RATE_W-1:0] req_effective_spads, req_ambient_rate, req_raw_range;
   logic [RATE_W-1:0] req_peak_signal_rate, rsp_dist_mm, rsp_requested_spads;
   logic [STAT_W-1:0] rsp_stat_code;
   logic [CSR_W-1:0]  csr_wdata;

   readout_type    pending_readouts[$];
   conversion_type expected_conversions[$];
   logic [GAIN_W-1:0] gain_reg;
   logic [RATE_W-1:0] target_reg;
   bit failed;
   bit gaps_on;
   int idle_left;
   int quiet_cycles;

   tof_result_range_status_dss dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic status_type map_device_status(logic [BYTE_W-1:0] dev,
                                                    logic [BYTE_W-1:0] stream);
      case (dev)
         DEV_HW_A, DEV_HW_B, DEV_HW_C, DEV_HW_D: return ST_HW;
         DEV_ROI:     return ST_ROI;
         DEV_SYNC:    return ST_SYNC;
         DEV_BOUNDS:  return ST_BOUNDS;
         DEV_SIGNAL:  return ST_SIGNAL;
         DEV_SIGMA:   return ST_SIGMA;
         DEV_WRAP:    return ST_WRAP;
         DEV_XTALK:   return ST_XTALK;
         DEV_MINCLIP: return ST_MINCLIP;
         DEV_RANGE:   return (stream == '0) ? ST_NOWRAP : ST_VALID;
         default:     return ST_NONE;
      endcase
   endfunction

   function automatic conversion_type convert_readout(readout_type r);
      conversion_type c;
      logic [63:0] scaled, rate_sum, per_spad, req;
      scaled = (64'(r.raw) * 64'(gain_reg) + 64'(ROUND_HALF)) >> 11;
      c.dist_mm = (scaled > 64'(CLIP16)) ? CLIP16 : scaled[RATE_W-1:0];
      c.status = map_device_status(r.dev, r.stream);
      if (r.spads == '0) begin
         c.spads_req = SPAD_MID;
      end else begin
         rate_sum = 64'(r.peak) + 64'(r.ambient);
         if (rate_sum > 64'(CLIP16)) rate_sum = 64'(CLIP16);
         per_spad = (rate_sum << 16) / 64'(r.spads);
         if (per_spad == 0) begin
            c.spads_req = SPAD_MID;
         end else begin
            req = (64'(target_reg) << 16) / per_spad;
            c.spads_req = (req > 64'(CLIP16)) ? CLIP16 : req[RATE_W-1:0];
         end
      end
      return c;
   endfunction

   function automatic readout_type random_readout();
      readout_type r;
      r = readout_type'({$urandom, $urandom, $urandom});
      case ($urandom_range(0, 3))
         0: r.dev = 8'($urandom_range(0, 20));
         1: r.dev = DEV_RANGE;
         default: ;
      endcase
      if ($urandom_range(0, 3) == 0) r.stream = '0;
      case ($urandom_range(0, 5))
         0: r.spads = 16'($urandom_range(0, 3));
         1: r.spads = 16'($urandom_range(256, 8192));
         default: ;
      endcase
      if ($urandom_range(0, 4) == 0) begin
         r.peak = 16'($urandom_range(0, 3));
         r.ambient = 16'($urandom_range(0, 3));
      end
      return r;
   endfunction

   // Driver: present the head item, hold start until accepted, idle in bursts.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         idle_left <= 0;
      end else if (start && !busy) begin
         expected_conversions.push_back(convert_readout(pending_readouts.pop_front()));
         if (gaps_on && $urandom_range(0, 7) == 0) begin
            idle_left <= $urandom_range(1, 11);
            start <= 1'b0;
         end else if (pending_readouts.size() > 0) begin
            {req_device_status, req_stream_count, req_effective_spads,
             req_ambient_rate, req_raw_range, req_peak_signal_rate}
               <= pending_readouts[0];
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end else if (idle_left > 0) begin
         idle_left <= idle_left - 1;
      end else if (!start && pending_readouts.size() > 0) begin
         {req_device_status, req_stream_count, req_effective_spads,
          req_ambient_rate, req_raw_range, req_peak_signal_rate}
            <= pending_readouts[0];
         start <= 1'b1;
      end
   end

   // Monitor: compare every strobed result with the oldest expectation.
   always @(posedge clock) begin
      conversion_type e;
      if (!reset && rsp_valid) begin
         if (expected_conversions.size() == 0) begin
            $display("%0t: unexpected result mm=%0d st=%0d spads=%0d", $time,
                     rsp_dist_mm, rsp_stat_code, rsp_requested_spads);
            failed = 1'b1;
         end else begin
            e = expected_conversions.pop_front();
            if (rsp_dist_mm !== e.dist_mm) begin
               $display("%0t: dist_mm expected %0d actual %0d", $time,
                        e.dist_mm, rsp_dist_mm);
               failed = 1'b1;
            end
            if (rsp_stat_code !== e.status) begin
               $display("%0t: stat_code expected %0d actual %0d", $time,
                        e.status, rsp_stat_code);
               failed = 1'b1;
            end
            if (rsp_requested_spads !== e.spads_req) begin
               $display("%0t: requested_spads expected %0d actual %0d", $time,
                        e.spads_req, rsp_requested_spads);
               failed = 1'b1;
            end
         end
      end
   end

   // Watchdog: count cycles with nothing accepted on either side.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic drain();
      wait (pending_readouts.size() == 0 && !start);
      wait (expected_conversions.size() == 0);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_RANGE_GAIN) gain_reg = value[GAIN_W-1:0];
      else target_reg = value;
   endtask

   initial begin
      readout_type r;
      logic [BYTE_W-1:0] d;
      failed = 1'b0;
      gaps_on = 1'b1;
      gain_reg = GAIN_RESET;
      target_reg = TARGET_RESET;
      reset = 1'b1;
      start = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_RANGE_GAIN;
      csr_wdata = '0;
      {req_device_status, req_stream_count, req_effective_spads,
       req_ambient_rate, req_raw_range, req_peak_signal_rate} = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: every defined device status byte, extremes, zero divisors, overflow.
      for (int i = 0; i <= 19; i++) begin
         d = 8'(i);
         if (i == 19) d = 8'hFF;
         pending_readouts.push_back(readout_type'({d, 8'(i), 16'(i * 97 + 1),
                                                16'(i * 3000), 16'(i * 3449), 16'(i * 50)}));
      end
      pending_readouts.push_back(readout_type'({DEV_RANGE, 8'h00, 16'h0, 16'h10, 16'h10,
                                                16'h10}));
      pending_readouts.push_back(readout_type'({DEV_RANGE, 8'hFF, 16'hFFFF, 16'h0, 16'hFFFF,
                                                16'h0}));
      pending_readouts.push_back(readout_type'({DEV_HW_A, 8'h01, 16'h0001, 16'hFFFF, 16'h0,
                                                16'hFFFF}));
      pending_readouts.push_back(readout_type'({DEV_XTALK, 8'h80, 16'hFFFF, 16'h0, 16'h8000,
                                                16'h1}));
      drain();

      write_reg(CSR_RANGE_GAIN, 16'hFFFF);
      write_reg(CSR_DSS_TARGET, 16'hFFFF);
      for (int ph = 0; ph < 5; ph++) begin
         if (ph == 1) begin
            write_reg(CSR_RANGE_GAIN, 16'h0000);
            write_reg(CSR_DSS_TARGET, 16'h0000);
         end else if (ph > 1) begin
            write_reg(CSR_RANGE_GAIN, 16'($urandom));
            write_reg(CSR_DSS_TARGET, 16'($urandom));
         end
         if (ph == 4) gaps_on = 1'b0;
         for (int n = 0; n < 285; n++) begin
            r = random_readout();
            if (n < 2) r = (n == 0) ? '1 : '0;
            pending_readouts.push_back(r);
         end
         // Pause the sender until all results are back.
         drain();
      end

      if (!failed) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
